// File: hdl/olist_pkg.sv
// ----------------------------------------------------------------------------
// olist_pkg: shared types and codes for the ordered list block
// Item layouts for both channels, operation and status codes, and the
// sequencer states.
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;
  localparam logic [1:0] KIND_NOP    = 2'd3;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] item_value;
    logic [5:0]         position;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] found_position;
    logic [6:0] list_length;
    logic       is_empty;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEL,
    S_FIND,
    S_DONE
  } state_t;

endpackage

// File: hdl/ordered_list_append_delete_search.sv
// Append and no-op: the item goes through the done state to the output register.
// Delete reads each entry after the position and writes it one place lower; lookup
// reads from the head until the first match or the end of the list.
// Both scans go one entry per cycle through the single read port of the value memory.
// One item is worked on at a time; a finished result may wait in the output register.
// Reset empties the list at once; the value memory is not cleared.
// ----------------------------------------------------------------------------
// ordered_list_append_delete_search: bounded ordered list of signed values
// Append at the tail, delete at a position with the gap closed, and lookup of
// the first position holding a value, over a single memory and a sequencer.
// ----------------------------------------------------------------------------
module ordered_list_append_delete_search #(
  parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  olist_pkg::in_t   in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output olist_pkg::out_t  out_item
);

  // Address width indexes the memory; the count width can hold CAPACITY itself.
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 6) ? CW : 6;

  olist_pkg::state_t state, state_next;

  // Entry storage. Entries at and beyond the count are never read.
  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rdata;

  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      rd_idx, rd_idx_next;
  logic [CW-1:0]      pend_idx, pend_idx_next;
  logic [CW-1:0]      pend_prev;
  logic               pend, pend_next;
  logic signed [31:0] value, value_next;
  logic [1:0]         res_status, res_status_next;
  logic [5:0]         res_found, res_found_next;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;
  logic               rd_en;

  logic               in_fire;
  logic               out_free;
  logic               more;
  logic               scan_end;
  logic               hit;
  logic               full;
  logic               range_err;

  assign in_ready  = (state == olist_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Scan control: more entries left to read, and nothing still in flight.
  assign more      = (rd_idx < count);
  assign scan_end  = !more && !pend;
  assign pend_prev = pend_idx - CW'(1);

  // The one shared comparator: registered read data against the searched value.
  assign hit       = pend && (rdata == value);

  assign full      = (count >= CW'(CAPACITY));
  assign range_err = (PW'(in_item.position) >= PW'(count));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      olist_pkg::S_IDLE: begin
        if (in_fire) begin
          if ((in_item.kind == olist_pkg::KIND_DELETE) && !range_err) begin
            state_next = olist_pkg::S_DEL;
          end else if (in_item.kind == olist_pkg::KIND_LOOKUP) begin
            state_next = olist_pkg::S_FIND;
          end else begin
            state_next = olist_pkg::S_DONE;
          end
        end
      end
      olist_pkg::S_DEL: begin
        if (scan_end) begin
          state_next = olist_pkg::S_DONE;
        end
      end
      olist_pkg::S_FIND: begin
        if (hit || scan_end) begin
          state_next = olist_pkg::S_DONE;
        end
      end
      olist_pkg::S_DONE: begin
        if (out_free) begin
          state_next = olist_pkg::S_IDLE;
        end
      end
      default: state_next = olist_pkg::S_IDLE;
    endcase
  end

  // Datapath control and register next values.
  always_comb begin
    wr_en           = 1'b0;
    wr_addr         = count[AW-1:0];
    wr_data         = in_item.item_value;
    rd_en           = 1'b0;
    count_next      = count;
    rd_idx_next     = rd_idx;
    pend_next       = 1'b0;
    pend_idx_next   = rd_idx;
    value_next      = value;
    res_status_next = res_status;
    res_found_next  = res_found;

    unique case (state)
      olist_pkg::S_IDLE: begin
        if (in_fire) begin
          value_next      = in_item.item_value;
          res_status_next = olist_pkg::ST_DONE;
          res_found_next  = 6'd0;
          unique case (in_item.kind)
            olist_pkg::KIND_APPEND: begin
              if (full) begin
                res_status_next = olist_pkg::ST_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + CW'(1);
              end
            end
            olist_pkg::KIND_DELETE: begin
              if (range_err) begin
                res_status_next = olist_pkg::ST_RANGE;
              end else begin
                // The gap closes by moving each later entry down by one.
                rd_idx_next = CW'(in_item.position) + CW'(1);
              end
            end
            olist_pkg::KIND_LOOKUP: begin
              res_status_next = olist_pkg::ST_NOTFOUND;
              rd_idx_next     = '0;
            end
            olist_pkg::KIND_NOP: begin
              res_status_next = olist_pkg::ST_DONE;
            end
            default: res_status_next = olist_pkg::ST_DONE;
          endcase
        end
      end
      olist_pkg::S_DEL: begin
        if (more) begin
          rd_en         = 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = rd_idx;
          rd_idx_next   = rd_idx + CW'(1);
        end
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = pend_prev[AW-1:0];
          wr_data = rdata;
        end
        if (scan_end) begin
          count_next = count - CW'(1);
        end
      end
      olist_pkg::S_FIND: begin
        if (hit) begin
          res_status_next = olist_pkg::ST_DONE;
          res_found_next  = 6'(pend_idx);
        end else if (more) begin
          rd_en         = 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = rd_idx;
          rd_idx_next   = rd_idx + CW'(1);
        end
      end
      olist_pkg::S_DONE: begin
        pend_next = 1'b0;
      end
      default: pend_next = 1'b0;
    endcase
  end

  // Value memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_idx[AW-1:0]];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= olist_pkg::S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      if ((state == olist_pkg::S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers. The length is taken from the count once the operation is done.
  always_ff @(posedge clk) begin
    rd_idx     <= rd_idx_next;
    pend_idx   <= pend_idx_next;
    value      <= value_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    if ((state == olist_pkg::S_DONE) && out_free) begin
      out_item.status         <= res_status;
      out_item.found_position <= res_found;
      out_item.list_length    <= 7'(count);
      out_item.is_empty       <= (count == '0);
    end
  end

  // The count never passes the capacity.
  assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // An append into a list with room grows it by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && (in_item.kind == olist_pkg::KIND_APPEND) && !full)
      |=> (count == CW'($past(count) + CW'(1))))
    else $error("append did not grow the list by one");

  // A finished delete shrinks the list by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    ((state == olist_pkg::S_DEL) && scan_end)
      |=> ((state == olist_pkg::S_DONE) && (count == CW'($past(count) - CW'(1)))))
    else $error("delete did not shrink the list by one");

  // Shifting during a delete writes only inside the list.
  assert property (@(posedge clk) disable iff (rst)
    ((state == olist_pkg::S_DEL) && wr_en) |-> (pend_prev < count))
    else $error("delete shift writes outside the list");

  // A match ends the lookup with a done status.
  assert property (@(posedge clk) disable iff (rst)
    ((state == olist_pkg::S_FIND) && hit)
      |=> ((state == olist_pkg::S_DONE) && (res_status == olist_pkg::ST_DONE)))
    else $error("lookup match not reported as done");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the ordered list block
// Drives append, delete and lookup items through the valid/ready input and
// checks every result against a list kept inside the testbench. Both sides
// idle in short random bursts. The run covers the empty and the full list,
// positions out of range, lookups that miss, duplicate values and the
// no-op kind.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CAP         = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  // A delete or a failed lookup on a full list is the slowest item, so the
  // quiet tail after the last result covers two of those.
  localparam int TAIL_CYCLES = 2 * CAP + 16;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  // All inputs of the block start at known values; reset is high from time 0.
  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  olist_pkg::in_t  in_item   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  olist_pkg::out_t out_item;

  // The testbench's own copy of the list. It is updated at the moment an item
  // is accepted, so the sequence of updates follows the order of acceptance.
  logic signed [31:0] list_vals [0:CAP-1];
  int                 list_len = 0;

  // Results predicted for accepted items, oldest first.
  olist_pkg::out_t expected_results [$];

  int err_count   = 0;
  int result_idx  = 0;
  int cycle_count = 0;
  int stall_left  = 0;
  bit idle_on     = 1'b1;

  always #10 clk = ~clk;

  ordered_list_append_delete_search #(
    .CAPACITY(CAP)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  // Applies one item to the list copy and returns the result the block must
  // give for it. Entries at and beyond the length are never looked at.
  function automatic olist_pkg::out_t list_apply(input olist_pkg::in_t it);
    olist_pkg::out_t r;
    int              i;
    bit              hit;
    r.status         = olist_pkg::ST_DONE;
    r.found_position = '0;
    hit              = 1'b0;
    case (it.kind)
      olist_pkg::KIND_APPEND: begin
        if (list_len >= CAP) begin
          r.status = olist_pkg::ST_FULL;
        end else begin
          list_vals[list_len] = it.item_value;
          list_len++;
        end
      end
      olist_pkg::KIND_DELETE: begin
        if (int'(it.position) >= list_len) begin
          r.status = olist_pkg::ST_RANGE;
        end else begin
          // Close the gap by moving every later entry down by one.
          for (i = int'(it.position); i + 1 < list_len; i++) begin
            list_vals[i] = list_vals[i + 1];
          end
          list_len--;
        end
      end
      olist_pkg::KIND_LOOKUP: begin
        r.status = olist_pkg::ST_NOTFOUND;
        for (i = 0; i < list_len && !hit; i++) begin
          if (list_vals[i] == it.item_value) begin
            hit              = 1'b1;
            r.status         = olist_pkg::ST_DONE;
            r.found_position = i[5:0];
          end
        end
      end
      default: begin
        // The no-op kind leaves the list alone and reports it as it is.
      end
    endcase
    r.list_length = list_len[6:0];
    r.is_empty    = (list_len == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR: result %0d at cycle %0d: %s", result_idx, cycle_count, msg);
    err_count++;
  endtask

  // Sends one item. An idle burst may come first; valid then stays high with
  // the payload held until the block takes the item. Valid is left high on
  // return so that a following item can go out back to back; a pause lowers it.
  task automatic send_op(input logic [1:0] kind, input logic signed [31:0] val,
                         input logic [5:0] pos);
    olist_pkg::in_t it;
    int             gap;
    it.kind       = kind;
    it.item_value = val;
    it.position   = pos;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(list_apply(it));
  endtask

  // Holds the sender off until every result already owed has come back.
  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Output side: ready drops in random bursts while idling is enabled,
  // otherwise it stays high.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin : check_results
    olist_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no item waiting for it");
      end else begin
        want = expected_results.pop_front();
        if (out_item.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_item.status, want.status));
        if (out_item.found_position !== want.found_position)
          report_mismatch($sformatf("found_position got %0d want %0d",
                                    out_item.found_position, want.found_position));
        if (out_item.list_length !== want.list_length)
          report_mismatch($sformatf("list_length got %0d want %0d",
                                    out_item.list_length, want.list_length));
        if (out_item.is_empty !== want.is_empty)
          report_mismatch($sformatf("is_empty got %0b want %0b",
                                    out_item.is_empty, want.is_empty));
      end
      result_idx++;
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** ordered_list_append_delete_search: FAILED **");
      $finish;
    end
  end

  // Short hand-picked sequence: operations on the empty list, the extreme
  // values, duplicates, head, middle and tail deletes, and the no-op kind.
  task automatic test_directed_cases();
    send_op(olist_pkg::KIND_LOOKUP, 32'sd0, 6'd0);      // miss on an empty list
    send_op(olist_pkg::KIND_DELETE, 32'sd0, 6'd0);      // nothing to delete
    send_op(olist_pkg::KIND_DELETE, VAL_MAX, 6'd63);
    send_op(olist_pkg::KIND_NOP, VAL_MIN, 6'd63);
    send_op(olist_pkg::KIND_APPEND, VAL_MIN, 6'd0);
    send_op(olist_pkg::KIND_APPEND, VAL_MAX, 6'd0);
    send_op(olist_pkg::KIND_APPEND, 32'sd0, 6'd0);
    send_op(olist_pkg::KIND_APPEND, -32'sd1, 6'd0);
    send_op(olist_pkg::KIND_APPEND, 32'sd7, 6'd0);
    send_op(olist_pkg::KIND_APPEND, 32'sd7, 6'd0);      // duplicate value
    send_op(olist_pkg::KIND_LOOKUP, VAL_MIN, 6'd0);
    send_op(olist_pkg::KIND_LOOKUP, VAL_MAX, 6'd0);
    send_op(olist_pkg::KIND_LOOKUP, -32'sd1, 6'd0);
    send_op(olist_pkg::KIND_LOOKUP, 32'sd7, 6'd0);      // first of the two sevens
    send_op(olist_pkg::KIND_LOOKUP, 32'sd12345, 6'd0);  // miss on a filled list
    send_op(olist_pkg::KIND_DELETE, 32'sd0, 6'd6);      // position equal to length
    send_op(olist_pkg::KIND_DELETE, 32'sd0, 6'd5);      // tail
    send_op(olist_pkg::KIND_DELETE, 32'sd0, 6'd0);      // head
    send_op(olist_pkg::KIND_LOOKUP, VAL_MAX, 6'd0);
    send_op(olist_pkg::KIND_DELETE, 32'sd0, 6'd2);      // middle
    send_op(olist_pkg::KIND_LOOKUP, 32'sd7, 6'd0);
    send_op(olist_pkg::KIND_NOP, 32'sd0, 6'd0);
  endtask

  // Fills the list to capacity, then works at both ends of the full list.
  task automatic test_capacity_edges();
    while (list_len < CAP) begin
      send_op(olist_pkg::KIND_APPEND, 32'sd1000 + list_len, 6'($urandom()));
    end
    send_op(olist_pkg::KIND_APPEND, VAL_MIN, 6'd0);          // dropped, list full
    send_op(olist_pkg::KIND_APPEND, VAL_MAX, 6'd63);
    send_op(olist_pkg::KIND_LOOKUP, list_vals[CAP-1], 6'd0); // match in the last entry
    send_op(olist_pkg::KIND_LOOKUP, -32'sd12345, 6'd0);      // full-length scan, miss
    send_op(olist_pkg::KIND_DELETE, 32'sd0, 6'(CAP - 1));    // tail of a full list
    send_op(olist_pkg::KIND_APPEND, -32'sd7, 6'd0);
    send_op(olist_pkg::KIND_DELETE, 32'sd0, 6'd0);
    send_op(olist_pkg::KIND_DELETE, 32'sd0, 6'(CAP - 1));    // now out of range
    send_op(olist_pkg::KIND_LOOKUP, -32'sd7, 6'd0);
  endtask

  // The sender waits for the block to go fully quiet, then restarts with
  // long operations straight from idle.
  task automatic test_drain_pause();
    send_op(olist_pkg::KIND_APPEND, 32'sd3, 6'd0);
    send_op(olist_pkg::KIND_LOOKUP, 32'sd3, 6'd0);
    pause_until_drained();
    send_op(olist_pkg::KIND_LOOKUP, 32'sd424242, 6'd0);
    pause_until_drained();
    send_op(olist_pkg::KIND_DELETE, 32'sd0, 6'd0);
    send_op(olist_pkg::KIND_APPEND, VAL_MIN, 6'd0);
    pause_until_drained();
  endtask

  // Random mix in chunks. Each chunk steers the length toward a target, so
  // the list swings between empty, small, medium and full. Lookups mostly
  // ask for a value that is present, and deletes mostly hit a valid position.
  task automatic test_random_mix(input int n_items, input bit allow_idle);
    int                 sent;
    int                 chunk_end;
    int                 target;
    int                 r;
    int                 p_app;
    logic [1:0]         kind;
    logic signed [31:0] val;
    logic [5:0]         pos;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 9))
        0:       target = 0;
        1:       target = CAP;
        2, 3:    target = $urandom_range(8, 40);
        default: target = $urandom_range(1, 8);
      endcase
      idle_on   = allow_idle && ($urandom_range(0, 3) != 0);
      chunk_end = sent + $urandom_range(20, 80);
      while (sent < n_items && sent < chunk_end) begin
        r   = $urandom_range(0, 99);
        val = $urandom();
        pos = 6'($urandom());
        if (list_len < target) p_app = 80;
        else if (list_len > target) p_app = 20;
        else p_app = 50;
        if (r < 4) begin
          kind = olist_pkg::KIND_NOP;
        end else if (r < 40) begin
          kind = olist_pkg::KIND_LOOKUP;
          if (list_len > 0 && $urandom_range(0, 9) < 7)
            val = list_vals[$urandom_range(0, list_len - 1)];
          else if ($urandom_range(0, 1) == 0)
            val = int'($urandom_range(0, 6)) - 3;
        end else if ($urandom_range(0, 99) < p_app) begin
          kind = olist_pkg::KIND_APPEND;
          // Small values make duplicates common.
          case ($urandom_range(0, 9))
            0:       val = VAL_MIN;
            1:       val = VAL_MAX;
            2, 3, 4: val = int'($urandom_range(0, 6)) - 3;
            default: ;
          endcase
        end else begin
          kind = olist_pkg::KIND_DELETE;
          if (list_len > 0 && $urandom_range(0, 9) < 8)
            pos = 6'($urandom_range(0, list_len - 1));
        end
        send_op(kind, val, pos);
        sent++;
      end
      if ($urandom_range(0, 7) == 0) pause_until_drained();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_capacity_edges();
    test_drain_pause();
    test_random_mix(1700, 1'b1);
    // Last stretch runs at full rate on both sides.
    idle_on = 1'b0;
    test_random_mix(200, 1'b0);

    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("** ordered_list_append_delete_search: PASSED **");
    end else begin
      $display("** ordered_list_append_delete_search: FAILED **");
    end
    $finish;
  end

endmodule
